// ----- rtl/tt_pkg.sv -----
`default_nettype none
package tt_pkg;
    localparam int TABLE_SLOTS = 4096;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int ENTRY_W = 64 + 16 + 8 + 32 + 2;
    localparam logic [15:0] NO_MOVE = 16'hFFFF;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_PV    = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_ALPHA = 2'd1;
    localparam logic [1:0] BOUND_BETA  = 2'd2;
    localparam logic [1:0] BOUND_EXACT = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [63:0]        key;
        logic [15:0]        move;
        logic               move_invalid;
        logic signed [31:0] score;
        logic [7:0]         depth;
        logic [1:0]         bound_flag;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
    } t_in_item;

    typedef struct packed {
        logic               cutoff;
        logic               key_match;
        logic [15:0]        move_out;
        logic signed [31:0] score_out;
        logic               error;
        logic [31:0]        new_writes;
        logic [31:0]        overwrites;
        logic [31:0]        hits;
    } t_out_item;

    typedef struct packed {
        logic [63:0]        key;
        logic [15:0]        move;
        logic [7:0]         depth;
        logic signed [31:0] score;
        logic [1:0]         bound;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic div_start;
        logic clr_start;
        logic finish;    // evaluate and build result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic clr_done;
        logic [1:0] opcode;
        logic move_invalid;
    } t_sts;

    function automatic t_entry empty_entry();
        t_entry e;
        e.key = '0;
        e.move = NO_MOVE;
        e.depth = '0;
        e.score = '0;
        e.bound = BOUND_NONE;
        return e;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/transposition_table.sv -----
`default_nettype none
// Transposition table, always-replace, 4096 slots in one RAM. For store, probe
// and PV probe the item passes through decode, the 64-step remainder unit that
// maps the key to a slot, the RAM read and the result register; a store with an
// invalid move goes from decode straight to the result and is rejected. A clear
// walks all 4096 slots, one per cycle, and its result is built when the walk
// ends. The same clearing pass runs after reset, and no item is taken until it
// has finished. One item is worked at a time; input is stalled until the result
// register has been taken.
module transposition_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [12:0]       i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire tt_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tt_pkg::t_out_item      o_out_data
);
    tt_pkg::t_cmd w_cmd;
    tt_pkg::t_sts w_sts;

    tt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out_data)
    );
endmodule
`default_nettype wire

// ----- rtl/tt_ram.sv -----
`default_nettype none
module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/tt_ctrl.sv -----
`default_nettype none
module tt_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    input  wire tt_pkg::t_sts i_sts,
    output tt_pkg::t_cmd     o_cmd
);
    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_DECO = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_CLR  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // input taken only when the output register is free
    assign o_in_stall  = !(r_state == S_IDLE && !r_out_valid);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd = '0;
        case (r_state)
            S_INIT: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !r_out_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECO;
                end
            end
            S_DECO: begin
                if (i_sts.opcode == tt_pkg::OP_CLEAR) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_CLR;
                end else if (i_sts.opcode == tt_pkg::OP_STORE && i_sts.move_invalid) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_CLR: begin
                if (i_sts.clr_done) begin
                    n_state = S_FIN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tt_dp.sv -----
`default_nettype none
module tt_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [12:0]      i_cfg_wdata,
    input  wire tt_pkg::t_in_item i_in,
    input  wire tt_pkg::t_cmd     i_cmd,
    output tt_pkg::t_sts          o_sts,
    output tt_pkg::t_out_item     o_out
);
    localparam int SW = tt_pkg::SLOT_W;
    localparam int CW = tt_pkg::CNT_W;

    tt_pkg::t_in_item r_req;
    tt_pkg::t_out_item r_out;
    logic [12:0]   r_cfg;
    logic [31:0]   r_nw, r_ow, r_hit;

    // restoring division remainder, one quotient bit a cycle
    logic [CW-1:0] r_div_n;
    logic [63:0]   r_div_q;
    logic [CW:0]   r_rem;
    logic [6:0]    r_div_cnt;
    logic          r_div_busy, r_div_done;
    logic [CW:0]   w_shift, w_sub;
    logic [CW-1:0] w_n_clamped;

    // clearing pass after reset and on clear
    logic          r_clr_busy, r_clr_done;
    logic [SW-1:0] r_clr_addr;

    logic          r_init;

    logic          w_we;
    logic [SW-1:0] w_waddr, w_slot;
    tt_pkg::t_entry w_wdata, w_rdata;

    always_comb begin
        if (r_cfg == '0) begin
            w_n_clamped = CW'(1);
        end else if (32'(r_cfg) > 32'(tt_pkg::TABLE_SLOTS)) begin
            w_n_clamped = CW'(tt_pkg::TABLE_SLOTS);
        end else begin
            w_n_clamped = CW'(r_cfg);
        end
    end

    assign w_shift = {r_rem[CW-1:0], r_div_q[63]};
    assign w_sub   = w_shift - {1'b0, r_div_n};
    assign w_slot  = r_rem[SW-1:0];

    always_comb begin
        w_we = 1'b0;
        w_waddr = w_slot;
        w_wdata = '{key: r_req.key, move: r_req.move, depth: r_req.depth,
                    score: r_req.score, bound: r_req.bound_flag};
        if (r_clr_busy) begin
            w_we = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = tt_pkg::empty_entry();
        end else if (i_cmd.finish && r_req.opcode == tt_pkg::OP_STORE
                     && !r_req.move_invalid) begin
            w_we = 1'b1;
        end
    end

    tt_ram #(.WIDTH(tt_pkg::ENTRY_W), .DEPTH(tt_pkg::TABLE_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_slot),
        .o_rdata(w_rdata)
    );

    assign o_sts.div_done = r_div_done;
    assign o_sts.clr_done = r_clr_done;
    assign o_sts.opcode = r_req.opcode;
    assign o_sts.move_invalid = r_req.move_invalid;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 13'd4096;
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_clr_busy <= 1'b0;
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
            r_init <= 1'b1;
            r_nw <= '0;
            r_ow <= '0;
            r_hit <= '0;
        end else begin
            r_init <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_div_done <= 1'b0;
            r_clr_done <= 1'b0;
            if (r_init || i_cmd.clr_start) begin
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == SW'(tt_pkg::TABLE_SLOTS - 1)) begin
                    r_clr_busy <= 1'b0;
                    r_clr_done <= 1'b1;
                end
            end
            if (i_cmd.clr_start) begin
                r_nw <= '0;
                r_ow <= '0;
                r_hit <= '0;
            end
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt <= '0;
                r_div_q <= r_req.key;
                r_rem <= '0;
                r_div_n <= w_n_clamped;
            end else if (r_div_busy) begin
                r_div_q <= {r_div_q[62:0], 1'b0};
                r_rem <= w_sub[CW] ? w_shift : w_sub;
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == 7'd63) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out.cutoff <= 1'b0;
                r_out.key_match <= 1'b0;
                r_out.move_out <= tt_pkg::NO_MOVE;
                r_out.score_out <= '0;
                r_out.error <= 1'b0;
                r_out.new_writes <= r_nw;
                r_out.overwrites <= r_ow;
                r_out.hits <= r_hit;
                case (r_req.opcode)
                    tt_pkg::OP_STORE: begin
                        if (r_req.move_invalid) begin
                            r_out.error <= 1'b1;
                        end else if (w_rdata.key == '0) begin
                            r_nw <= r_nw + 1'b1;
                            r_out.new_writes <= r_nw + 1'b1;
                        end else begin
                            r_ow <= r_ow + 1'b1;
                            r_out.overwrites <= r_ow + 1'b1;
                        end
                    end
                    tt_pkg::OP_PROBE: begin
                        if (w_rdata.key == r_req.key) begin
                            r_out.key_match <= 1'b1;
                            r_out.move_out <= w_rdata.move;
                            if (w_rdata.depth >= r_req.depth) begin
                                r_hit <= r_hit + 1'b1;
                                r_out.hits <= r_hit + 1'b1;
                                if (w_rdata.bound == tt_pkg::BOUND_ALPHA
                                    && w_rdata.score <= r_req.alpha) begin
                                    r_out.cutoff <= 1'b1;
                                    r_out.score_out <= r_req.alpha;
                                end else if (w_rdata.bound == tt_pkg::BOUND_BETA
                                    && w_rdata.score >= r_req.beta) begin
                                    r_out.cutoff <= 1'b1;
                                    r_out.score_out <= r_req.beta;
                                end else if (w_rdata.bound == tt_pkg::BOUND_EXACT) begin
                                    r_out.cutoff <= 1'b1;
                                    r_out.score_out <= w_rdata.score;
                                end
                            end
                        end
                    end
                    tt_pkg::OP_PV: begin
                        if (w_rdata.key == r_req.key) begin
                            r_out.key_match <= 1'b1;
                            r_out.move_out <= w_rdata.move;
                            r_out.score_out <= w_rdata.score;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (i_cmd.load) begin
            r_req <= i_in;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tt_checker.sv -----
`default_nettype none
module tt_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire tt_pkg::t_out_item o_out_data
);
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result shown right after accept");
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> !o_out_data.key_match && !o_out_data.cutoff)
        else $error("error result with match");
endmodule

bind transposition_table tt_checker u_tt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
`default_nettype wire
